[design/lfgd_pkg.sv]
// Shared types, codes and the gamma table builder for the LED frame encoder.
// No dependencies; lfgd_seq, lfgd_color and the top level import this package.

package lfgd_pkg;

    // Number of color channels per LED
    localparam int CHANNELS = 3;
    localparam int CH_W     = 2;

    // Frame header bytes
    localparam logic [7:0] HDR_A     = 8'h41;
    localparam logic [7:0] HDR_D     = 8'h64;
    localparam logic [7:0] HDR_A_LOW = 8'h61;
    localparam logic [7:0] HDR_SALT  = 8'h55;

    // Sequencer steps: six header bytes, then red, green, blue
    typedef logic [3:0] step_t;
    localparam step_t STEP_HDR_A    = 4'd0;
    localparam step_t STEP_HDR_D    = 4'd1;
    localparam step_t STEP_HDR_A2   = 4'd2;
    localparam step_t STEP_CNT_HI   = 4'd3;
    localparam step_t STEP_CNT_LO   = 4'd4;
    localparam step_t STEP_CHECK    = 4'd5;
    localparam step_t STEP_RED      = 4'd6;
    localparam step_t STEP_GREEN    = 4'd7;
    localparam step_t STEP_BLUE     = 4'd8;

    // Control word that travels with each issued byte
    typedef struct packed {
        logic            is_color;   // color byte, else header byte
        logic [CH_W-1:0] chan;       // channel of a color byte
        logic            clr;        // first LED of a frame: carried error reads as zero
        logic            frame_end;
        logic            run_end;
    } issue_ctl_t;

    // Gamma 1.6 entry: largest v with v^5 * 255^3 <= i^8 * 2^(5*f).
    // Evaluated at elaboration only.
    function automatic int gamma_entry(input int i, input int f);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        rhs = 128'd1;
        for (int k = 0; k < 8; k++)
            rhs = rhs * 128'(i);
        rhs = rhs << (5 * f);
        lo = 32'd0;
        hi = 32'd255 << f;
        for (int n = 0; n < 32; n++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + 32'd1) >> 1);
                lhs = 128'd1;
                for (int k = 0; k < 5; k++)
                    lhs = lhs * 128'(mid);
                for (int k = 0; k < 3; k++)
                    lhs = lhs * 128'd255;
                if (lhs <= rhs)
                    lo = mid;
                else
                    hi = mid - 32'd1;
            end
        end
        return int'(lo);
    endfunction

endpackage

[design/lfgd_if.sv]
// Valid/ready channel interfaces: pixel input, frame byte output, config write.
// Depends on nothing.

interface lfgd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface lfgd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_end;
    modport source (output valid, out_byte, frame_end, run_end, input ready);
    modport sink   (input valid, out_byte, frame_end, run_end, output ready);
endinterface

interface lfgd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] led_count_minus_one;
    modport source (output valid, led_count_minus_one, input ready);
    modport sink   (input valid, led_count_minus_one, output ready);
endinterface

[design/lfgd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.

module lfgd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 3
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/lfgd_seq.sv]
// Byte sequencer: holds one pixel, steps through header and color bytes,
// tracks the LED position, looks up gamma and issues error memory reads.
// Depends on lfgd_pkg.

module lfgd_seq
    import lfgd_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // pixel channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   red,
    input  logic [7:0]                   green,
    input  logic [7:0]                   blue,
    input  logic [15:0]                  led_count,
    // issue toward the color stage
    input  logic                         s1_free,
    output logic                         iss_valid,
    output issue_ctl_t                   iss_ctl,
    output logic [7:0]                   iss_byte,
    output logic [FRACTION_BITS+7:0]     iss_gamma,
    // error memory read
    output logic                         rd_en,
    output logic [CH_W-1:0]              rd_addr
);

    localparam int GW = FRACTION_BITS + 8;

    // Gamma table, built at elaboration
    logic [GW-1:0] gamma_tab [256];

    for (genvar i = 0; i < 256; i++)
    begin : g_gamma
        localparam int GVAL = gamma_entry(i, FRACTION_BITS);
        assign gamma_tab[i] = GW'(GVAL);
    end

    logic        cur_valid_reg, cur_valid_next;
    logic [7:0]  cur_red_reg, cur_green_reg, cur_blue_reg;
    logic        cur_hdr_reg;
    logic        cur_last_reg;
    step_t       step_reg, step_next;
    logic [15:0] pos_reg, pos_next;

    logic        accept;
    logic        issue;
    logic        done;
    logic        last_led;
    logic        is_color;
    logic [CH_W-1:0] chan;
    logic [7:0]  pix;
    logic [7:0]  cnt_hi, cnt_lo;

    assign issue    = cur_valid_reg & s1_free;
    assign done     = issue & (step_reg == STEP_BLUE);
    assign in_ready = ~cur_valid_reg | done;
    assign accept   = in_valid & in_ready;
    assign last_led = pos_reg >= led_count;

    // Control: holding slot, step counter, LED position
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        if (accept)
        begin
            cur_valid_next = 1'b1;
            step_next      = (pos_reg == 16'd0) ? STEP_HDR_A : STEP_RED;
            pos_next       = last_led ? 16'd0 : pos_reg + 16'd1;
        end
        else if (done)
            cur_valid_next = 1'b0;
        else if (issue)
            step_next = step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_HDR_A;
            pos_reg       <= 16'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
        end
    end

    // Pixel payload and per-item flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_red_reg   <= red;
            cur_green_reg <= green;
            cur_blue_reg  <= blue;
            cur_hdr_reg   <= (pos_reg == 16'd0);
            cur_last_reg  <= last_led;
        end
    end

    // Byte selection for the current step
    assign cnt_hi   = led_count[15:8];
    assign cnt_lo   = led_count[7:0];
    assign is_color = step_reg >= STEP_RED;
    assign chan     = CH_W'(step_reg - STEP_RED);

    always_comb
    begin
        case (step_reg)
            STEP_HDR_A:  iss_byte = HDR_A;
            STEP_HDR_D:  iss_byte = HDR_D;
            STEP_HDR_A2: iss_byte = HDR_A_LOW;
            STEP_CNT_HI: iss_byte = cnt_hi;
            STEP_CNT_LO: iss_byte = cnt_lo;
            STEP_CHECK:  iss_byte = cnt_hi ^ cnt_lo ^ HDR_SALT;
            default:     iss_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        case (step_reg)
            STEP_RED:   pix = cur_red_reg;
            STEP_GREEN: pix = cur_green_reg;
            default:    pix = cur_blue_reg;
        endcase
    end

    assign iss_gamma = gamma_tab[pix];
    assign iss_valid = issue;

    always_comb
    begin
        iss_ctl.is_color  = is_color;
        iss_ctl.chan      = chan;
        iss_ctl.clr       = cur_hdr_reg;
        iss_ctl.run_end   = (step_reg == STEP_BLUE);
        iss_ctl.frame_end = (step_reg == STEP_BLUE) & cur_last_reg;
    end

    // Error memory read for color bytes
    assign rd_en   = issue & is_color;
    assign rd_addr = chan;

endmodule

[design/lfgd_color.sv]
// Color stage: applies carried error to the rounded gamma value, writes the
// new error back to memory, and holds the output byte register.
// Depends on lfgd_pkg.

module lfgd_color
    import lfgd_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // issue from the sequencer
    input  logic                         iss_valid,
    input  issue_ctl_t                   iss_ctl,
    input  logic [7:0]                   iss_byte,
    input  logic [FRACTION_BITS+7:0]     iss_gamma,
    output logic                         s1_free,
    // error memory
    input  logic [FRACTION_BITS+1:0]     rd_data,
    output logic                         wr_en,
    output logic [CH_W-1:0]              wr_addr,
    output logic [FRACTION_BITS+1:0]     wr_data,
    // output byte channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         frame_end,
    output logic                         run_end
);

    localparam int F  = FRACTION_BITS;
    localparam int GW = F + 8;
    localparam int EW = F + 2;
    localparam int SW = F + 3;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);

    logic               s1_valid_reg, s1_valid_next;
    issue_ctl_t         s1_ctl_reg;
    logic [7:0]         s1_byte_reg;
    logic [GW-1:0]      s1_gamma_reg;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               frame_end_reg;
    logic               run_end_reg;

    logic               out_free;
    logic               s1_adv;

    logic [GW:0]               round_sum;
    logic [8:0]                base_w;
    logic signed [SW-1:0]      e_old, resid, e_sum, corr, e_new;
    logic signed [10:0]        act_w;
    logic [7:0]                clamp_w;

    // Handshake between stages
    assign out_free = ~out_valid_reg | out_ready;
    assign s1_adv   = s1_valid_reg & out_free;
    assign s1_free  = ~s1_valid_reg | out_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (iss_valid)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (iss_valid)
        begin
            s1_ctl_reg   <= iss_ctl;
            s1_byte_reg  <= iss_byte;
            s1_gamma_reg <= iss_gamma;
        end
    end

    // Gamma rounding and error diffusion
    always_comb
    begin
        round_sum = {1'b0, s1_gamma_reg} + (GW + 1)'(HALF);
        base_w    = round_sum[GW:F];
        // residue of the rounding, in [-half, half)
        resid     = SW'(signed'({s1_gamma_reg[F-1], s1_gamma_reg[F-1:0]}));
        e_old     = s1_ctl_reg.clr ? '0 : SW'(signed'(rd_data));
        e_sum     = e_old + resid;
        if (e_sum >= 0)
            corr = (e_sum + HALF) >>> F;
        else
            corr = -((-e_sum + HALF) >>> F);
        e_new     = e_sum - (corr <<< F);
        act_w     = signed'({2'b00, base_w}) + 11'(corr);
        if (act_w < 0)
            clamp_w = 8'd0;
        else if (act_w > 11'sd255)
            clamp_w = 8'd255;
        else
            clamp_w = act_w[7:0];
    end

    // Error write-back
    assign wr_en   = s1_adv & s1_ctl_reg.is_color;
    assign wr_addr = s1_ctl_reg.chan;
    assign wr_data = e_new[EW-1:0];

    // Output register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_byte_reg  <= s1_ctl_reg.is_color ? clamp_w : s1_byte_reg;
            frame_end_reg <= s1_ctl_reg.frame_end;
            run_end_reg   <= s1_ctl_reg.run_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign run_end   = run_end_reg;

endmodule

[design/led_frame_gamma_dither_encoder.sv]
// LED frame encoder with gamma 1.6 correction and per-channel error diffusion.
// Depends on lfgd_pkg, lfgd_if, lfgd_ram, lfgd_seq and lfgd_color.
//
// Usage:
//   pixel  - one RGB pixel per transfer (red, green, blue).
//   led    - one frame byte per transfer; frame_end marks the blue byte of
//            the last LED, run_end the last byte caused by a pixel.
//   cfg    - writes led_count_minus_one; always ready; to be written only while idle, which the block does not enforce.
// A pixel at LED position zero first produces the six-byte header
// ('A','d','a', count high, count low, high ^ low ^ 0x55) and clears the
// carried error; every pixel then produces its red, green, blue bytes.
// Throughput: one byte per cycle while the receiver is ready, set by the single
// output byte lane. The first byte of a pixel passes the holding slot, the
// error read and the output register in turn before it is valid; the carried
// error lives in a 3-entry RAM whose registered read is issued with the byte,
// ahead of its use in the color stage.
// Reset clears position, count and valid flags; the first pixel after reset
// starts a frame. When the receiver stalls, the output register holds and
// the stages behind it fill, then pixel.ready drops.

module led_frame_gamma_dither_encoder
    import lfgd_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    lfgd_pixel_if.sink    pixel,
    lfgd_byte_if.source   led,
    lfgd_cfg_if.sink      cfg
);

    localparam int GW = FRACTION_BITS + 8;
    localparam int EW = FRACTION_BITS + 2;

    logic [15:0]     led_count_reg;

    logic            s1_free;
    logic            iss_valid;
    issue_ctl_t      iss_ctl;
    logic [7:0]      iss_byte;
    logic [GW-1:0]   iss_gamma;
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    logic [EW-1:0]   rd_data;
    logic            wr_en;
    logic [CH_W-1:0] wr_addr;
    logic [EW-1:0]   wr_data;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            led_count_reg <= 16'd0;
        else if (cfg.valid)
            led_count_reg <= cfg.led_count_minus_one;
    end

    // Sequencer
    lfgd_seq #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .red       (pixel.red),
        .green     (pixel.green),
        .blue      (pixel.blue),
        .led_count (led_count_reg),
        .s1_free   (s1_free),
        .iss_valid (iss_valid),
        .iss_ctl   (iss_ctl),
        .iss_byte  (iss_byte),
        .iss_gamma (iss_gamma),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // Carried error memory, one entry per channel
    lfgd_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_err_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Error diffusion and output register
    lfgd_color #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .iss_valid (iss_valid),
        .iss_ctl   (iss_ctl),
        .iss_byte  (iss_byte),
        .iss_gamma (iss_gamma),
        .s1_free   (s1_free),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (led.valid),
        .out_ready (led.ready),
        .out_byte  (led.out_byte),
        .frame_end (led.frame_end),
        .run_end   (led.run_end)
    );

endmodule

[test/tb.sv]
// Testbench for led_frame_gamma_dither_encoder: pixels in, frame bytes checked one by one.
// Needs lfgd_pkg, the lfgd_if channel interfaces and the encoder RTL.
// A class predicts each pixel's header, gamma and dither bytes and matches them in order.

module tb
    import lfgd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = 8;
    localparam int HALF      = 1 << (FRAC - 1);
    localparam int GAMMA_TOP = 255 << FRAC;
    localparam int SETTLE    = 10;
    localparam int LIMIT     = 500000;

    // One predicted byte of the serial frame
    typedef struct {
        logic [7:0] value;
        logic       frame_end;
        logic       run_end;
    } led_byte_t;

    // Frame encoder prediction and in-order byte matching
    class frame_byte_tracker;
        led_byte_t   pending_bytes[$];
        int          gamma_lut[256];
        logic [15:0] led_count;
        logic [15:0] led_pos;
        int          dither_err[3];
        int          mismatch_count;

        function new();
            bit [127:0] bound;
            bit [127:0] trial;
            int         v;
            bit         done;
            // g(i): largest v with v^5 * 255^3 <= i^8 * 2^(5*FRAC); monotone in i
            v = 0;
            for (int i = 0; i < 256; i++)
            begin
                bound = 128'd1;
                for (int k = 0; k < 8; k++)
                    bound = bound * 128'(i);
                bound = bound << (5 * FRAC);
                done = 1'b0;
                while (!done && v < GAMMA_TOP)
                begin
                    trial = 128'd1;
                    for (int k = 0; k < 5; k++)
                        trial = trial * 128'(v + 1);
                    for (int k = 0; k < 3; k++)
                        trial = trial * 128'd255;
                    if (trial <= bound)
                        v++;
                    else
                        done = 1'b1;
                end
                gamma_lut[i] = v;
            end
            led_count      = '0;
            led_pos        = '0;
            dither_err     = '{0, 0, 0};
            mismatch_count = 0;
        endfunction

        function void set_count(logic [15:0] v);
            led_count = v;
        endfunction

        function void push_byte(logic [7:0] v, logic fe, logic re);
            led_byte_t b;
            b.value     = v;
            b.frame_end = fe;
            b.run_end   = re;
            pending_bytes = {pending_bytes, b};
        endfunction

        // Work out every byte one accepted pixel produces
        function void encode_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic [7:0] hi8;
            logic [7:0] lo8;
            logic [7:0] chan[3];
            bit         last_led;
            int         gq;
            int         level;
            int         corr;
            hi8  = led_count[15:8];
            lo8  = led_count[7:0];
            chan = '{r, g, b};
            // frame opens: header, and the carried error starts over
            if (led_pos == 16'd0)
            begin
                push_byte(HDR_A, 1'b0, 1'b0);
                push_byte(HDR_D, 1'b0, 1'b0);
                push_byte(HDR_A_LOW, 1'b0, 1'b0);
                push_byte(hi8, 1'b0, 1'b0);
                push_byte(lo8, 1'b0, 1'b0);
                push_byte(hi8 ^ lo8 ^ HDR_SALT, 1'b0, 1'b0);
                dither_err = '{0, 0, 0};
            end
            last_led = (led_pos >= led_count);
            for (int c = 0; c < 3; c++)
            begin
                gq    = gamma_lut[chan[c]];
                level = (gq + HALF) >> FRAC;
                dither_err[c] += gq - (level << FRAC);
                // half rounds away from zero
                if (dither_err[c] >= 0)
                    corr = (dither_err[c] + HALF) >> FRAC;
                else
                    corr = -((HALF - dither_err[c]) >> FRAC);
                level += corr;
                dither_err[c] -= corr * (1 << FRAC);
                // clamp only the sent byte, not the error
                if (level < 0)
                    level = 0;
                if (level > 255)
                    level = 255;
                push_byte(level[7:0], (c == 2) && last_led, c == 2);
            end
            led_pos = last_led ? 16'd0 : led_pos + 16'd1;
        endfunction

        function void compare_led_byte(logic [7:0] v, logic fe, logic re);
            led_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte %02h with no prediction waiting", v);
                mismatch_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (v !== want.value)
                begin
                    $error("out_byte: expected %02h, actual %02h", want.value, v);
                    mismatch_count++;
                end
                if (fe !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, fe);
                    mismatch_count++;
                end
                if (re !== want.run_end)
                begin
                    $error("run_end: expected %0b, actual %0b", want.run_end, re);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lfgd_pixel_if pixel_ch ();
    lfgd_byte_if  led_ch ();
    lfgd_cfg_if   cfg_ch ();

    frame_byte_tracker tracker = new();

    bit calm;        // both sides run without gaps
    int rx_hold;     // cycles the receiver still holds off
    int rx_stall;

    led_frame_gamma_dither_encoder #(
        .FRACTION_BITS(FRAC)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .led   (led_ch),
        .cfg   (cfg_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(0, 255));
        if (r < 85)
            return 8'($urandom_range(0, 6));
        return (r < 93) ? 8'd255 : 8'($urandom_range(250, 254));
    endfunction

    // Offer one pixel and hold it until the transfer; returns at a falling edge
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_ch.valid <= 1'b1;
        pixel_ch.red   <= r;
        pixel_ch.green <= g;
        pixel_ch.blue  <= b;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        tracker.encode_pixel(r, g, b);
        @(negedge clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic pixel_gap(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        send_pixel(r, g, b);
        idle_gap(pick_gap());
    endtask

    // Stop offering and wait out every predicted byte plus the pipeline depth
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        while (tracker.pending_bytes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_count(input logic [15:0] v);
        cfg_ch.valid               <= 1'b1;
        cfg_ch.led_count_minus_one <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        tracker.set_count(v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    initial
    begin
        led_ch.ready = 1'b0;
        rx_stall     = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                led_ch.ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                led_ch.ready <= 1'b0;
            end
            else
            begin
                led_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
            end
        end
    end

    // Output monitor: every byte transfer is matched in order
    always @(posedge clk)
    begin
        if (rst_n && led_ch.valid && led_ch.ready)
            tracker.compare_led_byte(led_ch.out_byte, led_ch.frame_end, led_ch.run_end);
    end

    // Stimulus
    initial
    begin
        logic [15:0] phase_count[8];
        phase_count = '{16'd1, 16'd0, 16'd4, 16'd3, 16'hFFFF, 16'd2,
                        16'($urandom_range(5, 20)), 16'($urandom_range(0, 65535))};
        calm    = 1'b0;
        rx_hold = 0;
        rst_n   = 1'b0;
        pixel_ch.valid = 1'b0;
        pixel_ch.red   = 8'd0;
        pixel_ch.green = 8'd0;
        pixel_ch.blue  = 8'd0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.led_count_minus_one = 16'd0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // count at reset value: every pixel opens and closes a frame
        pixel_gap(8'd0, 8'd0, 8'd0);
        pixel_gap(8'd255, 8'd255, 8'd255);
        pixel_gap(8'd128, 8'd1, 8'd254);
        drain();

        // three-LED frames, then dark levels that push the error to the clamp
        write_count(16'd2);
        pixel_gap(8'd1, 8'd2, 8'd3);
        pixel_gap(8'd254, 8'd253, 8'd252);
        pixel_gap(8'd127, 8'd128, 8'd129);
        pixel_gap(8'd3, 8'd0, 8'd2);
        pixel_gap(8'd0, 8'd3, 8'd0);
        pixel_gap(8'd2, 8'd2, 8'd0);
        pixel_gap(8'd0, 8'd0, 8'd3);
        pixel_gap(8'd255, 8'd255, 8'd255);
        pixel_gap(8'd255, 8'd0, 8'd255);
        drain();

        // count lowered mid-frame: next pixel ends the frame with no header
        write_count(16'd5);
        pixel_gap(8'd10, 8'd20, 8'd30);
        pixel_gap(8'd40, 8'd50, 8'd60);
        drain();
        write_count(16'd0);
        pixel_gap(8'd70, 8'd80, 8'd90);
        pixel_gap(8'd100, 8'd110, 8'd120);
        drain();

        // largest count: header ff ff 55, frame never closes here
        write_count(16'hFFFF);
        pixel_gap(8'd255, 8'd0, 8'd0);
        pixel_gap(8'd0, 8'd255, 8'd0);
        pixel_gap(8'd0, 8'd0, 8'd255);
        drain();
        write_count(16'h5AA5);
        pixel_gap(8'd85, 8'd170, 8'd85);
        drain();

        // random phases, one count setting each
        for (int p = 0; p < 8; p++)
        begin
            write_count(phase_count[p]);
            calm = (p == 5);
            if (p == 2)
                rx_hold = 300;
            for (int n = 0; n < 40; n++)
            begin
                send_pixel(pick_level(), pick_level(), pick_level());
                // during the hold-off the sender keeps offering with no gaps
                if (!(p == 2 && n < 40 && rx_hold > 0))
                    idle_gap(pick_gap());
                if (p == 0 && n == 19)
                    drain();
            end
            drain();
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending_bytes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
design/lfgd_pkg.sv
design/lfgd_if.sv
design/lfgd_ram.sv
design/lfgd_seq.sv
design/lfgd_color.sv
design/led_frame_gamma_dither_encoder.sv
test/tb.sv
